FILE: rtl/sorted_table_exponential_search_macros.svh
// assertion helpers shared by the rtl modules
`ifndef SORTED_TABLE_EXPONENTIAL_SEARCH_MACROS_SVH
`define SORTED_TABLE_EXPONENTIAL_SEARCH_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define STES_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define STES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/stes_pkg.sv
package stes_pkg;

    // field widths
    localparam int LEN_W     = 11;
    localparam int IDX_W     = 10;
    localparam int KEY_W     = 32;
    localparam int POS_W     = 11;
    localparam int CNT_W     = LEN_W + 1;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    // parameter defaults
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_WORD_BITS   = 32;

    // command codes carried on tuser
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXP,
        S_SETUP,
        S_HALF,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wr_entry;
        logic start;
        logic exp_next;
        logic half_init;
        logic half_next;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic len_zero;
        logic len_gt1;
        logic exp_more;
        logic half_more;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/stes_ctrl.sv
`include "sorted_table_exponential_search_macros.svh"

module stes_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_cmd,
    input  stes_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output stes_pkg::t_dp_cmd  o_cmd
);
    import stes_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_cmd == CMD_SEARCH) begin
                    if (i_stat.len_zero) begin
                        n_state = S_DONE;
                    end else if (i_stat.len_gt1) begin
                        n_state = S_EXP;
                    end else begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_EXP: begin
                n_state = i_stat.exp_more ? S_EXP : S_SETUP;
            end
            S_SETUP: begin
                n_state = S_HALF;
            end
            S_HALF: begin
                n_state = i_stat.half_more ? S_HALF : S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.start    = i_in_valid && (i_in_cmd == CMD_SEARCH);
                o_cmd.wr_entry = i_in_valid && (i_in_cmd == CMD_WRITE);
            end
            S_EXP: begin
                o_cmd.exp_next = 1'b1;
            end
            S_SETUP: begin
                o_cmd.half_init = 1'b1;
            end
            S_HALF: begin
                o_cmd.half_next = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `STES_ASSERT_IMPL(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0(o_cmd), "two commands at once")
    `STES_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n, o_cmd.start, r_state != S_IDLE, "search did not leave idle")
    `STES_ASSERT_NEXT(a_done_leaves, i_clk, i_rst_n, o_cmd.out_load, r_state == S_IDLE, "result load did not return to idle")

endmodule

FILE: rtl/stes_dp.sv
`include "sorted_table_exponential_search_macros.svh"

module stes_dp #(
    parameter int TABLE_DEPTH = stes_pkg::DEF_TABLE_DEPTH,
    parameter int WORD_BITS   = stes_pkg::DEF_WORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [stes_pkg::LEN_W-1:0]    i_cfg_wdata,
    input  logic [stes_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [stes_pkg::KEY_W-1:0]    i_word_value,
    input  stes_pkg::t_dp_cmd             i_cmd,
    output stes_pkg::t_dp_stat            o_stat,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [stes_pkg::POS_W-1:0]    o_position
);
    import stes_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [WORD_BITS-1:0] r_mem [TABLE_DEPTH];
    logic [WORD_BITS-1:0] r_rdata;
    logic [WORD_BITS-1:0] r_key;
    logic [WORD_BITS-1:0] w_word;
    logic [LEN_W-1:0]     r_len;
    logic [LEN_W-1:0]     n_len;
    logic [CNT_W-1:0]     r_bound, n_bound;
    logic [CNT_W-1:0]     r_lo, n_lo;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_out_valid;
    logic [POS_W-1:0]     r_out_pos;
    logic [CNT_W-1:0]     w_len;
    logic [CNT_W-1:0]     w_rd_ptr;
    logic                 w_lt;
    logic                 w_wr_ok;
    logic [CNT_W-1:0]     w_dbl;
    logic [CNT_W-1:0]     w_lo0, w_hi0, w_bnd1, w_cnt0;
    logic [CNT_W-1:0]     w_half, w_probe, w_lo1, w_cnt1;

    assign w_word  = WORD_BITS'(i_word_value);
    assign w_len   = CNT_W'(r_len);
    assign w_lt    = r_rdata < r_key;
    assign w_wr_ok = 32'(i_entry_index) < 32'(TABLE_DEPTH);

    // exponential phase
    assign w_dbl = r_bound << 1;

    // window setup from the final bound
    assign w_lo0  = r_bound >> 1;
    assign w_bnd1 = r_bound + CNT_W'(1);
    assign w_hi0  = (w_bnd1 > w_len) ? w_len : w_bnd1;
    assign w_cnt0 = w_hi0 - w_lo0;

    // halving step
    assign w_half  = r_cnt >> 1;
    assign w_probe = r_lo + w_half;
    assign w_lo1   = w_lt ? (w_probe + CNT_W'(1)) : r_lo;
    assign w_cnt1  = w_lt ? (r_cnt - w_half - CNT_W'(1)) : w_half;

    always_comb begin
        n_bound  = r_bound;
        n_lo     = r_lo;
        n_cnt    = r_cnt;
        w_rd_ptr = w_lo1 + (w_cnt1 >> 1);
        if (i_cmd.start) begin
            n_bound  = CNT_W'(1);
            n_lo     = '0;
            w_rd_ptr = CNT_W'(1);
        end else if (i_cmd.exp_next) begin
            n_bound  = w_lt ? w_dbl : r_bound;
            w_rd_ptr = w_dbl;
        end else if (i_cmd.half_init) begin
            n_lo     = w_lo0;
            n_cnt    = w_cnt0;
            w_rd_ptr = w_lo0 + (w_cnt0 >> 1);
        end else if (i_cmd.half_next) begin
            n_lo  = w_lo1;
            n_cnt = w_cnt1;
        end
    end

    always_comb begin
        n_len = r_len;
        if (i_cfg_we) begin
            n_len = (32'(i_cfg_wdata) > 32'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : i_cfg_wdata;
        end
    end

    // table memory, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry && w_wr_ok) begin
            r_mem[AW'(i_entry_index)] <= w_word;
        end
        r_rdata <= r_mem[AW'(w_rd_ptr)];
    end

    always_ff @(posedge i_clk) begin
        r_bound <= n_bound;
        r_lo    <= n_lo;
        r_cnt   <= n_cnt;
        if (i_cmd.start) begin
            r_key <= w_word;
        end
        if (i_cmd.out_load) begin
            r_out_pos <= POS_W'(r_lo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len <= n_len;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.len_zero  = (r_len == '0);
    assign o_stat.len_gt1   = (r_len > LEN_W'(1));
    assign o_stat.exp_more  = w_lt && (w_dbl < w_len);
    assign o_stat.half_more = (w_cnt1 != '0);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_position  = r_out_pos;

    `STES_ASSERT_IMPL(a_exp_in_range, i_clk, i_rst_n, i_cmd.exp_next, r_bound < w_len, "probe bound past length")
    `STES_ASSERT_IMPL(a_half_nonempty, i_clk, i_rst_n, i_cmd.half_next, r_cnt != '0, "halving step on empty window")
    `STES_ASSERT_IMPL(a_pos_in_range, i_clk, i_rst_n, i_cmd.out_load, r_lo <= w_len, "result beyond length")

endmodule

FILE: rtl/sorted_table_exponential_search.sv
// channel     dir  handshake                      payload
// s_axis      in   s_axis_tvalid / s_axis_tready  tuser command, tdata index and word
// m_axis      out  m_axis_tvalid / m_axis_tready  tdata position
// cfg         in   i_cfg_we (no wait)             i_cfg_wdata table length
//
// a write transfer is taken whenever the block is idle and stores the entry
// a search runs e probes doubling the bound, a window setup and h halving probes,
//   one probe a cycle on the table memory read port, then hands off its position
// an empty table skips the doubling and halving probes and answers position zero
// reset clears the state machine, length and result valid; table contents stay unknown
// a held result lets writes through but holds the next search at its final step,
//   and no input is taken until that search hands off its position

module sorted_table_exponential_search #(
    parameter int TABLE_DEPTH = stes_pkg::DEF_TABLE_DEPTH,
    parameter int WORD_BITS   = stes_pkg::DEF_WORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // table length register write
    input  logic                              i_cfg_we,
    input  logic [stes_pkg::LEN_W-1:0]        i_cfg_wdata,
    // command stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [stes_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // entry_index[9:0], word_value[41:10]
    input  logic                              s_axis_tuser,  // command
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [stes_pkg::M_TDATA_W-1:0]    m_axis_tdata   // position[10:0]
);
    import stes_pkg::*;

    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;
    logic [POS_W-1:0] w_position;

    // sequencer: idle, doubling probes, window setup, halving probes, result hand-off
    stes_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // table memory, search registers and output register
    stes_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .WORD_BITS   (WORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_entry_index (s_axis_tdata[IDX_W-1:0]),
        .i_word_value  (s_axis_tdata[IDX_W+KEY_W-1:IDX_W]),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_position    (w_position)
    );

    // pad position to whole bytes
    assign m_axis_tdata = M_TDATA_W'(w_position);

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

// stream-level check of the sorted table search block
// a queue of table operations feeds a clocked driver, a clocked monitor checks each
// position against a predictor that mirrors the table contents and the probe order

module tb;
    import stes_pkg::*;

    localparam int          DEPTH       = DEF_TABLE_DEPTH;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          HOLD_CYCLES = 400;

    // one command transfer as the testbench sees it
    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] word;
    } t_table_op;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [LEN_W-1:0]     i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // entry_index[9:0], word_value[41:10]
    logic                 s_axis_tuser  = 1'b0; // command
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // position[10:0]

    sorted_table_exponential_search u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // stimulus side: operations waiting for the driver and a shadow of the table
    // used only to choose sensible keys and to keep unwritten entries out of reach
    t_table_op   pending_ops[$];
    int          ops_outstanding = 0;
    logic [31:0] gen_table[DEPTH];
    bit          gen_written[DEPTH];
    int unsigned gen_len = 0;

    // idle control, changed per phase
    int unsigned s_idle_pct  = 0;
    int unsigned r_stall_pct = 0;
    logic        rx_hold_req  = 1'b0;
    int unsigned rx_hold_left = 0;

    // predictor state, written by the driver; the monitor pops the predicted positions
    logic [31:0] pred_table[DEPTH];
    int unsigned pred_len = 0;
    t_table_op   cur_op;
    logic [POS_W-1:0] position_q[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // doubling probe then halving lower bound, same probe order as the block
    function automatic logic [POS_W-1:0] lower_bound_position(input logic [31:0] key);
        int unsigned n, bound, lo, hi, count, half, probe;
        n = pred_len;
        if (n == 0)
            return '0;
        bound = 1;
        while (bound < n && pred_table[bound] < key)
            bound = bound * 2;
        lo = bound / 2;
        hi = bound + 1;
        if (hi > n)
            hi = n;
        count = hi - lo;
        while (count > 0) begin
            half  = count / 2;
            probe = lo + half;
            if (pred_table[probe] < key) begin
                lo    = probe + 1;
                count = count - (half + 1);
            end else begin
                count = half;
            end
        end
        return lo[POS_W-1:0];
    endfunction

    // upper bits follow the index so that a table filled this way stays sorted
    function automatic logic [31:0] sorted_word(input int unsigned idx);
        return {idx[9:0], 22'($urandom())};
    endfunction

    task automatic push_write(input int unsigned idx, input logic [31:0] val);
        t_table_op op;
        op.cmd  = CMD_WRITE;
        op.idx  = idx[IDX_W-1:0];
        op.word = val;
        gen_table[idx]   = val;
        gen_written[idx] = 1'b1;
        ops_outstanding++;
        pending_ops.push_back(op);
    endtask

    task automatic push_search(input logic [31:0] key);
        t_table_op op;
        op.cmd  = CMD_SEARCH;
        op.idx  = IDX_W'($urandom());  // ignored by the block, toggled anyway
        op.word = key;
        ops_outstanding++;
        pending_ops.push_back(op);
    endtask

    function automatic logic [31:0] pick_key();
        logic [31:0] k;
        int unsigned i;
        i = (gen_len == 0) ? 0 : $urandom_range(gen_len - 1);
        case ($urandom_range(9))
            0:       k = '0;
            1:       k = '1;
            2, 3:    k = (gen_len == 0) ? $urandom() : gen_table[i];
            4:       k = (gen_len == 0) ? $urandom() : gen_table[i] + 1;
            5:       k = (gen_len == 0) ? $urandom() : gen_table[i] - 1;
            6, 7:    k = {10'($urandom_range(gen_len)), 22'($urandom())};
            default: k = $urandom();
        endcase
        return k;
    endfunction

    task automatic random_ops(input int unsigned n);
        int unsigned lim, idx;
        lim = (gen_len == 0) ? 1 : gen_len;
        repeat (n) begin
            if ($urandom_range(3) != 0) begin
                push_search(pick_key());
            end else begin
                idx = $urandom_range(lim - 1);
                case ($urandom_range(9))
                    6: begin
                        // anywhere in the table, any value
                        push_write($urandom_range(DEPTH - 1), $urandom());
                    end
                    7: push_write(idx, $urandom());  // breaks the sort order
                    8, 9: begin
                        // duplicate of the entry below
                        if (idx > 0 && gen_written[idx - 1])
                            push_write(idx, gen_table[idx - 1]);
                        else
                            push_write(idx, sorted_word(idx));
                    end
                    default: push_write(idx, sorted_word(idx));
                endcase
            end
        end
    endtask

    // the block is idle once every operation was taken and every position came back
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (ops_outstanding != 0 || position_q.size() != 0);
        // a trailing write may still be in progress
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_table_length(input logic [LEN_W-1:0] len);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gen_len = (len > DEPTH) ? DEPTH : len;
        // every entry below the length gets written before any search reads it
        for (int unsigned i = 0; i < gen_len; i++)
            if (!gen_written[i])
                push_write(i, sorted_word(i));
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] len, input int unsigned n,
                             input int unsigned s_pct, input int unsigned r_pct,
                             input bit hold);
        set_table_length(len);
        s_idle_pct  <= s_pct;
        r_stall_pct <= r_pct;
        if (hold) begin
            // receiver backs off while the sender keeps offering
            rx_hold_req <= 1'b1;
            @(posedge i_clk);
            rx_hold_req <= 1'b0;
        end
        random_ops(n);
    endtask

    // driver: presents the next operation, updates the predictor on each transfer
    always @(posedge i_clk) begin : drive
        t_table_op op_next;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we)
                pred_len = (i_cfg_wdata > DEPTH) ? DEPTH : i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                if (cur_op.cmd == CMD_WRITE)
                    pred_table[cur_op.idx] = cur_op.word;
                else
                    position_q.push_back(lower_bound_position(cur_op.word));
                ops_outstanding--;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= s_idle_pct) begin
                    op_next = pending_ops.pop_front();
                    cur_op  = op_next;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= op_next.cmd;
                    s_axis_tdata  <= {6'b0, op_next.word, op_next.idx};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here on its own
    always @(posedge i_clk) begin
        if (rx_hold_req)
            rx_hold_left <= HOLD_CYCLES;
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // monitor: checks each result transfer against the oldest predicted position
    always @(posedge i_clk) begin : watch
        logic [POS_W-1:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (position_q.size() == 0) begin
                    $display("%0t position %0d with no search outstanding",
                             $time, m_axis_tdata[POS_W-1:0]);
                    mismatch_count++;
                end else begin
                    want = position_q.pop_front();
                    if (m_axis_tdata[POS_W-1:0] !== want) begin
                        $display("%0t position mismatch: expected %0d actual %0d",
                                 $time, want, m_axis_tdata[POS_W-1:0]);
                        mismatch_count++;
                    end
                end
            end
            m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= r_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sorted_table_exponential_search verification failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: any key lands at position zero
        push_search('0);
        push_search('1);
        push_write(0, '0);
        push_write(DEPTH - 1, '1);
        push_search(32'h0001_2345);

        // single entry holding zero
        set_table_length(1);
        push_search('0);
        push_search(32'h1);
        push_search('1);

        // two entries, key equal to each, between and above
        set_table_length(2);
        push_write(1, 32'h100);
        push_search('0);
        push_search(32'h80);
        push_search(32'h100);
        push_search(32'h101);

        // duplicate entries at the end of the table
        set_table_length(3);
        push_write(2, 32'h100);
        push_search(32'h100);
        push_search('1);

        // random phases; length 2047 saturates to the full depth
        // filling the table up to each length adds writes for the entries not yet written
        run_phase(3,    20, 0,  0,  1'b0);
        run_phase(17,   30, 52, 0,  1'b0);
        run_phase(100,  60, 0,  0,  1'b1);
        run_phase(5,    20, 32, 32, 1'b0);
        run_phase(1000, 50, 0,  52, 1'b0);
        run_phase(2047, 40, 52, 0,  1'b0);
        run_phase(1024, 40, 32, 32, 1'b0);
        run_phase(0,    15, 0,  52, 1'b0);
        run_phase(64,   45, 32, 32, 1'b0);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (position_q.size() != 0) begin
            $display("%0t %0d searches never answered", $time, position_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("sorted_table_exponential_search verification clean");
        else
            $display("sorted_table_exponential_search verification failed");
        $finish;
    end

endmodule
